[src/tet_pkg.sv]
// Package for the timed event table: entry type, command codes, register indices, reset values.
// Used by tet_cell and timed_event_table_unit; no dependencies.
package tet_pkg;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_PURGE  = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    localparam logic [0:0] REG_PURGE_AGE = 1'b0;
    localparam logic [0:0] REG_LOOKAHEAD = 1'b1;
    localparam logic [31:0] PURGE_AGE_RST = 32'd900;
    localparam logic [31:0] LOOKAHEAD_RST = 32'd2678400;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] start;
        logic [31:0] length;
        logic [3:0]  color;
        logic [3:0]  kind;
    } t_entry;

endpackage

[src/tet_cell.sv]
// One slot of the compacting chain: holds an entry and its valid bit.
// Depends on tet_pkg. Takes its right neighbor's entry when told to shift.
module tet_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  logic           i_load,
    input  logic           i_clear,
    input  tet_pkg::t_entry i_next,
    input  logic           i_next_valid,
    input  tet_pkg::t_entry i_new,
    output tet_pkg::t_entry o_entry,
    output logic           o_valid
);
    import tet_pkg::*;

    t_entry r_entry;
    logic   r_valid;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_new;
        end else if (i_shift) begin
            r_entry <= i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_shift) begin
            r_valid <= i_next_valid;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;
endmodule

[src/timed_event_table_unit.sv]
// Timed event table top level: cell chain, scan sequencer and result register.
// Depends on tet_pkg and tet_cell.
// Sequence: every command rotates the occupied cells past the head once, one a cycle;
//   an add that evicts rotates the chain twice more, an add then appends its entry,
//   and the result word is written last.
// Throughput: one command at a time; the next word is taken once the result is taken.
// Reset: synchronous active-low reset empties the table and restores the registers.
module timed_event_table_unit #(
    parameter int ENTRIES = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_now,
    input  logic [31:0] i_event_id,
    input  logic [31:0] i_start_time,
    input  logic [31:0] i_length_secs,
    input  logic [3:0]  i_color_code,
    input  logic [3:0]  i_kind_code,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_found,
    output logic [31:0] o_hit_id,
    output logic [31:0] o_hit_start,
    output logic [31:0] o_hit_length,
    output logic [3:0]  o_hit_color,
    output logic [3:0]  o_hit_kind,
    output logic [5:0]  o_removed,
    output logic        o_evicted,
    output logic [5:0]  o_occupancy,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import tet_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_FAR   = 6'b000100,
        S_EVICT = 6'b001000,
        S_APPND = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;
    logic [31:0] r_now, r_id, r_purge_age, r_lookahead;
    t_entry r_add;
    logic [CW-1:0] r_ptr, r_len, r_count, r_removed;
    logic [CW-1:0] r_far;
    logic [31:0]   r_far_start;
    logic          r_evicted;
    logic          r_cur_hit, r_soon_hit;
    t_entry        r_cur, r_soon;
    logic          r_out_valid;

    t_entry cell_q [ENTRIES];
    logic   cell_v [ENTRIES];
    logic   shift_en [ENTRIES];
    logic   load_en [ENTRIES];
    logic   clear_en [ENTRIES];

    // every pass looks at the head cell only
    t_entry       scan_e, new_e;
    logic [32:0]  scan_end, lim;
    logic [32:0]  thr;
    logic         del_hit, scan_active, rot_en, drop_en;
    assign scan_e   = cell_q[0];
    assign scan_end = {1'b0, scan_e.start} + {1'b0, scan_e.length};
    assign lim      = {1'b0, r_now} + {1'b0, r_lookahead};
    assign thr      = {1'b0, r_now} - {1'b0, r_purge_age};
    assign scan_active = (r_state == S_SCAN) && (r_ptr < r_len);
    assign rot_en = ((r_state == S_SCAN) || (r_state == S_FAR) || (r_state == S_EVICT))
                    && (r_ptr < r_len);
    assign drop_en = (scan_active && del_hit)
                     || ((r_state == S_EVICT) && rot_en && (r_ptr == r_far));
    assign new_e = (r_state == S_APPND) ? r_add : scan_e;

    always_comb begin
        case (r_cmd)
            CMD_ADD, CMD_REMOVE: del_hit = (scan_e.id == r_id);
            CMD_PURGE: del_hit = (r_now >= r_purge_age) && (scan_end <= thr);
            default: del_hit = 1'b0;
        endcase
    end

    // each step moves the chain left; a kept head re-enters at the tail
    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            t_entry nx;
            logic   nv;
            if (g == ENTRIES - 1) begin : g_last
                assign nx = cell_q[g];
                assign nv = 1'b0;
            end else begin : g_mid
                assign nx = cell_q[g+1];
                assign nv = cell_v[g+1];
            end
            assign shift_en[g] = rot_en;
            assign load_en[g]  = ((r_state == S_APPND) && (r_count == CW'(g)))
                                 || (rot_en && !drop_en && (r_count == CW'(g + 1)));
            assign clear_en[g] = 1'b0;
            tet_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_shift     (shift_en[g]),
                .i_load      (load_en[g]),
                .i_clear     (clear_en[g]),
                .i_next      (nx),
                .i_next_valid(nv),
                .i_new       (new_e),
                .o_entry     (cell_q[g]),
                .o_valid     (cell_v[g])
            );
        end
    endgenerate

    // a register write takes the edge before a command word
    assign o_ready     = (r_state == S_IDLE) && !r_out_valid && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_purge_age <= PURGE_AGE_RST;
            r_lookahead <= LOOKAHEAD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_PURGE_AGE) r_purge_age <= i_cfg_data;
            else r_lookahead <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_ptr       <= '0;
        end else begin
            if (r_out_valid && i_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    r_cmd <= t_cmd'(i_command);
                    r_now <= i_now;
                    r_id  <= i_event_id;
                    r_add <= '{id: i_event_id, start: i_start_time,
                               length: i_length_secs, color: i_color_code,
                               kind: i_kind_code};
                    r_ptr      <= '0;
                    r_len      <= r_count;
                    r_removed  <= '0;
                    r_evicted  <= 1'b0;
                    r_cur_hit  <= 1'b0;
                    r_soon_hit <= 1'b0;
                    r_far      <= '0;
                    r_far_start <= '0;
                    r_state    <= S_SCAN;
                end
                S_SCAN: begin
                    if (scan_active) begin
                        r_ptr <= r_ptr + 1'b1;
                        if (del_hit) begin
                            r_count   <= r_count - 1'b1;
                            r_removed <= r_removed + 1'b1;
                        end else begin
                            if (!r_cur_hit && r_now >= scan_e.start
                                && {1'b0, r_now} <= scan_end) begin
                                r_cur_hit <= 1'b1;
                                r_cur     <= scan_e;
                            end
                            if ({1'b0, scan_e.start} <= lim && (!r_soon_hit
                                || scan_e.start < r_soon.start)) begin
                                r_soon_hit <= 1'b1;
                                r_soon     <= scan_e;
                            end
                        end
                    end else if (r_cmd == CMD_ADD) begin
                        r_ptr <= '0;
                        r_len <= r_count;
                        r_state <= (r_count >= CW'(ENTRIES)) ? S_FAR : S_APPND;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_FAR: begin
                    // first entry with latest start
                    if (rot_en) begin
                        if (r_ptr == '0 || r_far_start < scan_e.start) begin
                            r_far       <= r_ptr;
                            r_far_start <= scan_e.start;
                        end
                        r_ptr <= r_ptr + 1'b1;
                    end else begin
                        r_ptr   <= '0;
                        r_state <= S_EVICT;
                    end
                end
                S_EVICT: begin
                    if (rot_en) begin
                        r_ptr <= r_ptr + 1'b1;
                        if (drop_en) begin
                            r_count   <= r_count - 1'b1;
                            r_evicted <= 1'b1;
                        end
                    end else begin
                        r_state <= S_APPND;
                    end
                end
                S_APPND: begin
                    r_count <= r_count + 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    t_entry hit_e;
    logic   hit_f;
    assign hit_f = (r_cmd == CMD_QUERY) && (r_cur_hit || r_soon_hit);
    assign hit_e = r_cur_hit ? r_cur : r_soon;

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            o_found      <= hit_f;
            o_hit_id     <= hit_f ? hit_e.id : '0;
            o_hit_start  <= hit_f ? hit_e.start : '0;
            o_hit_length <= hit_f ? hit_e.length : '0;
            o_hit_color  <= hit_f ? hit_e.color : '0;
            o_hit_kind   <= hit_f ? hit_e.kind : '0;
            o_removed    <= 6'(r_removed);
            o_evicted    <= r_evicted;
            o_occupancy  <= 6'(r_count);
        end
    end
    assign o_valid = r_out_valid;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES)) else $error("count above depth");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVICT) |-> (r_count >= CW'(ENTRIES - 1))) else $error("evict not full");
    a_out_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE)) else $error("stray result");
endmodule
